// File: rtl/core/pchd_pkg.sv
`timescale 1ns / 1ps

package pchd_pkg;

  // Action codes carried in the input tuser
  typedef logic [1:0] action_t;
  localparam action_t ACT_TICK   = 2'd0;
  localparam action_t ACT_SET    = 2'd1;
  localparam action_t ACT_HOME   = 2'd2;
  localparam action_t ACT_SAMPLE = 2'd3;

  // Range limits of the time of day
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HALF_DAY   = 5'd12;

  // Range limits checked on the 7-bit set-time fields
  localparam logic [6:0] SET_HOUR_MAX = 7'd23;
  localparam logic [6:0] SET_MIN_MAX  = 7'd59;

  // Hour pulses per hour carry before noon, one more from noon on
  localparam logic [5:0] HOUR_STEP_PULSES = 6'd2;

  // Home mark, 30/33 of full scale
  localparam logic [11:0] THRESH_RST = 12'd3723;

  typedef struct packed {
    logic [11:0] sensor_level;
    logic [6:0]  set_second;
    logic [6:0]  set_minute;
    logic [6:0]  set_hour;
    action_t     action;
  } in_item_t;

  // Timekeeper outcome for one item
  typedef struct packed {
    logic       start_homing;
    logic       refused;
    logic [5:0] hour_pulses;
    logic [5:0] minute_pulses;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tk_res_t;

  // Homing sequencer outcome for one item
  typedef struct packed {
    logic hour_pulse;
    logic minute_pulse;
    logic busy;
  } hm_res_t;

endpackage

// File: rtl/core/pchd_timekeeper.sv
`timescale 1ns / 1ps

module pchd_timekeeper (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pchd_pkg::in_item_t item,
  output pchd_pkg::tk_res_t  res
);

  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;

  // tick path
  logic       sec_carry, min_carry;
  logic [4:0] hour_inc;

  // set path
  logic       set_ok, need_home;
  logic [4:0] sh, base_h, span_lo, hr_span, pm_span;
  logic [5:0] sm, ss, base_m, set_hp, set_mp;

  assign sec_carry = (sec_r == pchd_pkg::MIN_LAST);
  assign min_carry = (min_r == pchd_pkg::MIN_LAST);
  assign hour_inc  = (hour_r == pchd_pkg::HOUR_LAST) ? 5'd0 : hour_r + 5'd1;

  assign set_ok = (item.set_hour <= pchd_pkg::SET_HOUR_MAX) &&
                  (item.set_minute <= pchd_pkg::SET_MIN_MAX) &&
                  (item.set_second <= pchd_pkg::SET_MIN_MAX);
  assign sh = item.set_hour[4:0];
  assign sm = item.set_minute[5:0];
  assign ss = item.set_second[5:0];

  // going backwards means homing first, then counting from 0:00
  assign need_home = (sh < hour_r) || (sm < min_r);
  assign base_h    = need_home ? 5'd0 : hour_r;
  assign base_m    = need_home ? 6'd0 : min_r;

  // two pulses per hour, one more for each hour from noon on
  assign span_lo = (base_h > pchd_pkg::HALF_DAY) ? base_h : pchd_pkg::HALF_DAY;
  assign hr_span = (sh > base_h)  ? sh - base_h  : 5'd0;
  assign pm_span = (sh > span_lo) ? sh - span_lo : 5'd0;
  assign set_hp  = {hr_span, 1'b0} + {1'b0, pm_span};
  assign set_mp  = (sm > base_m) ? sm - base_m : 6'd0;

  always_comb begin
    res      = '0;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    unique case (item.action)
      pchd_pkg::ACT_TICK: begin
        sec_nxt = sec_r + 6'd1;
        if (sec_carry) begin
          sec_nxt           = 6'd0;
          min_nxt           = min_r + 6'd1;
          res.minute_pulses = 6'd1;
          if (min_carry) begin
            min_nxt         = 6'd0;
            hour_nxt        = hour_inc;
            res.hour_pulses = pchd_pkg::HOUR_STEP_PULSES +
                              {5'd0, (hour_inc >= pchd_pkg::HALF_DAY)};
          end
        end
      end
      pchd_pkg::ACT_SET: begin
        if (!set_ok) begin
          res.refused = 1'b1;
        end else begin
          res.start_homing  = need_home;
          res.hour_pulses   = set_hp;
          res.minute_pulses = set_mp;
          hour_nxt          = sh;
          min_nxt           = sm;
          sec_nxt           = ss;
        end
      end
      pchd_pkg::ACT_HOME: begin
        res.start_homing = 1'b1;
      end
      default: begin
      end
    endcase
    res.hour   = hour_nxt;
    res.minute = min_nxt;
    res.second = sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r <= 5'd0;
      min_r  <= 6'd0;
      sec_r  <= 6'd0;
    end else if (adv) begin
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
    end
  end

endmodule

// File: rtl/core/pchd_homing.sv
`timescale 1ns / 1ps

module pchd_homing (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pchd_pkg::action_t action,
  input  logic              start,
  input  logic [11:0]       sensor_level,
  input  logic [11:0]       threshold,
  output pchd_pkg::hm_res_t res
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HOUR_RISE = 5'b00010,
    PH_HOUR_FALL = 5'b00100,
    PH_MIN_RISE  = 5'b01000,
    PH_MIN_FALL  = 5'b10000
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   above;

  assign above = (sensor_level >= threshold);

  always_comb begin
    phase_nxt        = phase_r;
    res.hour_pulse   = 1'b0;
    res.minute_pulse = 1'b0;
    if (start) begin
      phase_nxt = PH_HOUR_RISE;
    end else if (action == pchd_pkg::ACT_SAMPLE) begin
      unique case (phase_r)
        PH_HOUR_RISE: begin
          res.hour_pulse = 1'b1;
          if (above) phase_nxt = PH_HOUR_FALL;
        end
        PH_HOUR_FALL: begin
          res.hour_pulse = 1'b1;
          if (!above) phase_nxt = PH_MIN_RISE;
        end
        PH_MIN_RISE: begin
          res.minute_pulse = 1'b1;
          if (above) phase_nxt = PH_MIN_FALL;
        end
        PH_MIN_FALL: begin
          res.minute_pulse = 1'b1;
          if (!above) phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    res.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/core/pulse_clock_hand_driver_unit.sv
`timescale 1ns / 1ps

// Pulse clock hand driver. Keeps the time of day for a clock with pulse-driven
// hands and returns, for every input transaction, exactly one result
// transaction: the hour and minute hand pulses due, the homing flags, a
// refusal flag for an out-of-range set time, and the time after the item.
// Actions (in_tuser): tick adds a second, set time counts pulses from the old
// time (or from 0:00 after homing when the new time lies behind), start
// homing enters the hour-rise phase, and a sensor sample steps the homing
// phases against home_threshold (written on the cfg channel, reset 3723).
// Timing: an accepted item is registered in the input register, evaluated by
// short logic into the output register, and offered on out_ from there.
// One transaction per clock is sustained while out_tready is high; the input
// register and output register keep both sides decoupled, so a new item is
// taken while a finished result waits, and out_tready stalls propagate back
// only once both registers are full. Configuration is taken on any cycle
// (cfg_ready is always high) and is meant to be written while the block is
// idle.

module pulse_clock_hand_driver_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] set_hour, [13:7] set_minute, [20:14] set_second,
  // [32:21] sensor_level, [39:33] zero
  input  logic [39:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] hour_pulses, [11:6] minute_pulses, [12] homing_started,
  // [13] homing_busy, [14] set_refused, [19:15] cur_hour,
  // [25:20] cur_minute, [31:26] cur_second
  output logic [31:0] out_tdata,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  // home_threshold
  input  logic [11:0] cfg_data
);

  // configuration
  logic [11:0] threshold_r;

  // input register
  logic               in_valid_r, in_valid_nxt;
  pchd_pkg::in_item_t item_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic              adv;
  pchd_pkg::tk_res_t tk_res;
  pchd_pkg::hm_res_t hm_res;

  // item in the input register moves on when the output register is free
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= pchd_pkg::THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  pchd_timekeeper u_tk (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .res   (tk_res)
  );

  pchd_homing u_hm (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .action       (item_r.action),
    .start        (tk_res.start_homing),
    .sensor_level (item_r.sensor_level),
    .threshold    (threshold_r),
    .res          (hm_res)
  );

  // pulses from the timekeeper and from homing never coincide: homing
  // only pulses on samples, the timekeeper never does
  assign out_data_nxt = {tk_res.second,
                         tk_res.minute,
                         tk_res.hour,
                         tk_res.refused,
                         hm_res.busy,
                         tk_res.start_homing,
                         tk_res.minute_pulses | {5'd0, hm_res.minute_pulse},
                         tk_res.hour_pulses   | {5'd0, hm_res.hour_pulse}};

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= {in_tdata[32:21], in_tdata[20:14], in_tdata[13:7], in_tdata[6:0],
                 in_tuser};
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // held item must not be overwritten while the output side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(item_r)))
    else $error("input register lost a stalled transaction");

  // a refused set leaves no pulses and no homing start
  a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[14]) |->
      (out_data_r[11:0] == 12'd0 && !out_data_r[12]))
    else $error("refused set produced pulses or homing");

  // starting homing always leaves a homing phase active
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[12]) |-> out_data_r[13])
    else $error("homing started but not busy");

  // reported time stays within a day
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[19:15] <= pchd_pkg::HOUR_LAST &&
                     out_data_r[25:20] <= pchd_pkg::MIN_LAST &&
                     out_data_r[31:26] <= pchd_pkg::MIN_LAST))
    else $error("time out of range");

  // a result is produced only for an item that moved on
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !adv) |=> !out_valid_r)
    else $error("result appeared without an item");

endmodule

// File: tb/pulse_clock_hand_driver_unit_tb.sv
`timescale 1ns / 1ps

module pulse_clock_hand_driver_unit_tb;

  localparam int CLK_HALF   = 10;
  localparam int CYCLE_CAP  = 200000;
  localparam int ERR_SHOWN  = 10;

  // Homing phases as the predictor tracks them
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HOUR_RISE = 5'b00010,
    PH_HOUR_FALL = 5'b00100,
    PH_MIN_RISE  = 5'b01000,
    PH_MIN_FALL  = 5'b10000
  } home_phase_t;

  // Same bit order as out_tdata, lowest field last
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic       refused;
    logic       busy;
    logic       started;
    logic [5:0] minute_pulses;
    logic [5:0] hour_pulses;
  } hand_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;

  pulse_clock_hand_driver_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: time of day, homing phase and the home mark
  logic [4:0]   clk_hour    = '0;
  logic [5:0]   clk_minute  = '0;
  logic [5:0]   clk_second  = '0;
  home_phase_t  hm_phase    = PH_IDLE;
  logic [11:0]  home_mark   = pchd_pkg::THRESH_RST;

  hand_result_t due_results[$];

  bit free_run     = 1'b0;  // no gaps on either side while set
  int sink_hold    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int homing_count = 0;
  int refused_count = 0;
  int carry_count  = 0;
  int mark_writes  = 0;
  int cycle_count  = 0;

  // Works out the result of one accepted item and moves the predictor state on
  function automatic hand_result_t advance_clock(pchd_pkg::action_t act, logic [6:0] sh,
                                                 logic [6:0] sm, logic [6:0] ss,
                                                 logic [11:0] lvl);
    hand_result_t r;
    logic         above;
    logic [4:0]   from_h;
    logic [5:0]   from_m;
    int           h;
    r     = '0;
    above = (lvl >= home_mark);
    case (act)
      pchd_pkg::ACT_TICK: begin
        if (clk_second == pchd_pkg::MIN_LAST) begin
          clk_second      = '0;
          r.minute_pulses = 6'd1;
          if (clk_minute == pchd_pkg::MIN_LAST) begin
            clk_minute    = '0;
            clk_hour      = (clk_hour == pchd_pkg::HOUR_LAST) ? 5'd0 : clk_hour + 5'd1;
            // three pulses per hour past noon
            r.hour_pulses = (clk_hour >= pchd_pkg::HALF_DAY) ? 6'd3 : 6'd2;
          end else begin
            clk_minute = clk_minute + 6'd1;
          end
        end else begin
          clk_second = clk_second + 6'd1;
        end
      end
      pchd_pkg::ACT_SET: begin
        if (sh > 7'd23 || sm > 7'd59 || ss > 7'd59) begin
          r.refused = 1'b1;
        end else begin
          from_h = clk_hour;
          from_m = clk_minute;
          // a time behind the hands needs homing, then count from 0:00
          if (sh[4:0] < from_h || sm[5:0] < from_m) begin
            hm_phase  = PH_HOUR_RISE;
            r.started = 1'b1;
            from_h    = '0;
            from_m    = '0;
          end
          for (h = int'(from_h); h < int'(sh); h++)
            r.hour_pulses = r.hour_pulses + ((h >= 12) ? 6'd3 : 6'd2);
          r.minute_pulses = (sm[5:0] > from_m) ? sm[5:0] - from_m : 6'd0;
          clk_hour   = sh[4:0];
          clk_minute = sm[5:0];
          clk_second = ss[5:0];
        end
      end
      pchd_pkg::ACT_HOME: begin
        hm_phase  = PH_HOUR_RISE;
        r.started = 1'b1;
      end
      default: begin
        case (hm_phase)
          PH_HOUR_RISE: begin
            r.hour_pulses = 6'd1;
            if (above) hm_phase = PH_HOUR_FALL;
          end
          PH_HOUR_FALL: begin
            r.hour_pulses = 6'd1;
            if (!above) hm_phase = PH_MIN_RISE;
          end
          PH_MIN_RISE: begin
            r.minute_pulses = 6'd1;
            if (above) hm_phase = PH_MIN_FALL;
          end
          PH_MIN_FALL: begin
            r.minute_pulses = 6'd1;
            if (!above) hm_phase = PH_IDLE;
          end
          default: hm_phase = PH_IDLE;  // sample while idle is ignored
        endcase
      end
    endcase
    r.busy   = (hm_phase != PH_IDLE);
    r.hour   = clk_hour;
    r.minute = clk_minute;
    r.second = clk_second;
    return r;
  endfunction

  // One input transaction, preceded by a random gap unless free-running
  task automatic send_item(pchd_pkg::action_t act, logic [6:0] sh, logic [6:0] sm,
                           logic [6:0] ss, logic [11:0] lvl);
    int           gap;
    hand_result_t r;
    gap = free_run ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, lvl, ss, sm, sh};
    do @(posedge clk); while (!in_tready);
    r = advance_clock(act, sh, sm, ss, lvl);
    due_results.push_back(r);
    items_sent++;
    if (r.started) homing_count++;
    if (r.refused) refused_count++;
    if (act == pchd_pkg::ACT_TICK && r.minute_pulses != 0) carry_count++;
  endtask

  // Sender holds off until every outstanding result has been taken
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Home mark write, only once the block is idle
  task automatic write_home_mark(logic [11:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    home_mark = value;
    mark_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sensor levels biased towards the home mark so both crossings happen
  function automatic logic [11:0] pick_level();
    int v;
    case ($urandom_range(0, 9)) inside
      0: v = 0;
      1: v = 4095;
      [2:5]: v = int'(home_mark) + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // A start-homing transaction followed by a train of samples
  task automatic homing_run(int samples);
    send_item(pchd_pkg::ACT_HOME, 7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
              7'($urandom_range(0, 99)), 12'($urandom_range(0, 4095)));
    repeat (samples) begin
      if ($urandom_range(0, 9) == 0)
        send_item(pchd_pkg::ACT_TICK, 0, 0, 0, 12'($urandom_range(0, 4095)));
      else
        send_item(pchd_pkg::ACT_SAMPLE, 7'($urandom_range(0, 99)),
                  7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)), pick_level());
    end
  endtask

  // One random transaction of any kind
  task automatic random_item();
    int         pick;
    logic [6:0] sh, sm, ss;
    pick = $urandom_range(0, 99);
    sh   = 7'($urandom_range(0, 23));
    sm   = 7'($urandom_range(0, 59));
    ss   = 7'($urandom_range(0, 59));
    if (pick < 35) begin
      send_item(pchd_pkg::ACT_TICK, 7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                7'($urandom_range(0, 99)), 12'($urandom_range(0, 4095)));
    end else if (pick < 55) begin
      // often park just short of a carry so ticks roll minutes and hours
      if ($urandom_range(0, 2) == 0) begin
        ss = 7'd59;
        if ($urandom_range(0, 1) == 0) sm = 7'd59;
      end
      send_item(pchd_pkg::ACT_SET, sh, sm, ss, 12'($urandom_range(0, 4095)));
    end else if (pick < 62) begin
      case ($urandom_range(0, 3))
        0: sh = 7'($urandom_range(24, 99));
        1: sm = 7'($urandom_range(60, 99));
        2: ss = 7'($urandom_range(60, 99));
        default: begin
          sh = 7'($urandom_range(0, 99));
          sm = 7'($urandom_range(0, 99));
          ss = 7'($urandom_range(0, 99));
        end
      endcase
      send_item(pchd_pkg::ACT_SET, sh, sm, ss, 12'($urandom_range(0, 4095)));
    end else if (pick < 67) begin
      send_item(pchd_pkg::ACT_HOME, 0, 0, 0, 12'($urandom_range(0, 4095)));
    end else begin
      send_item(pchd_pkg::ACT_SAMPLE, 7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                7'($urandom_range(0, 99)), pick_level());
    end
  endtask

  // Extremes, every action and the named corner cases at the reset home mark
  task automatic test_directed();
    send_item(pchd_pkg::ACT_TICK,   0,  0,  0, 12'd0);     // plain tick
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, 12'd4095);  // sample while idle
    send_item(pchd_pkg::ACT_SET,   99, 99, 99, 12'd0);     // everything out of range
    send_item(pchd_pkg::ACT_SET,   24,  0,  0, 12'd0);     // hour just out of range
    send_item(pchd_pkg::ACT_SET,    0, 60,  0, 12'd0);     // minute just out of range
    send_item(pchd_pkg::ACT_SET,    0,  0, 60, 12'd0);     // second just out of range
    send_item(pchd_pkg::ACT_SET,   23, 59, 59, 12'd0);     // longest forward set
    send_item(pchd_pkg::ACT_TICK,   0,  0,  0, 12'd0);     // midnight roll-over
    send_item(pchd_pkg::ACT_SET,   11, 59, 59, 12'd0);
    send_item(pchd_pkg::ACT_TICK,   0,  0,  0, 12'd0);     // carry into noon
    send_item(pchd_pkg::ACT_SET,    5, 30,  0, 12'd0);     // behind: homing first
    send_item(pchd_pkg::ACT_TICK,   0,  0,  0, 12'd0);     // tick while homing
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, 12'd0);
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, 12'd4095);
    send_item(pchd_pkg::ACT_SET,    6, 40,  0, 12'd0);     // forward set while homing
    send_item(pchd_pkg::ACT_HOME,   0,  0,  0, 12'd0);     // restart while homing
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, pchd_pkg::THRESH_RST); // exactly on the mark
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, pchd_pkg::THRESH_RST - 12'd1);
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, 12'd4095);
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, 12'd0);     // back to idle
    send_item(pchd_pkg::ACT_SAMPLE, 0,  0,  0, 12'd0);
    send_item(pchd_pkg::ACT_SET,    7, 10,  0, 12'd0);     // hour ahead, minute behind
    send_item(pchd_pkg::ACT_SET,    0,  0,  0, 12'd0);     // back to midnight
    send_item(pchd_pkg::ACT_HOME,   0,  0,  0, 12'd0);
    wait_for_results();
  endtask

  // Homing against the lowest and highest home marks
  task automatic test_mark_extremes();
    write_home_mark(12'd0);
    homing_run(6);
    write_home_mark(12'd4095);
    homing_run(4);
    send_item(pchd_pkg::ACT_SAMPLE, 0, 0, 0, 12'd4094);
    send_item(pchd_pkg::ACT_SAMPLE, 0, 0, 0, 12'd4095);
    send_item(pchd_pkg::ACT_SAMPLE, 0, 0, 0, 12'd4094);
    send_item(pchd_pkg::ACT_SAMPLE, 0, 0, 0, 12'd4095);
    send_item(pchd_pkg::ACT_SAMPLE, 0, 0, 0, 12'd0);
    wait_for_results();
  endtask

  // Random mix over several home marks, one phase without any idling
  task automatic test_random_traffic();
    logic [11:0] marks[5];
    int          p;
    int          goal;
    bit          drained;
    marks[0] = 12'($urandom_range(1, 4094));
    marks[1] = pchd_pkg::THRESH_RST;
    marks[2] = 12'd1;
    marks[3] = 12'($urandom_range(0, 4095));
    marks[4] = 12'd4095;
    for (p = 0; p < 5; p++) begin
      write_home_mark(marks[p]);
      free_run = (p == 2);
      goal    = items_sent + 290;
      drained = 1'b0;
      while (items_sent < goal) begin
        if ($urandom_range(0, 4) == 0)
          homing_run($urandom_range(2, 10));
        else
          random_item();
        // mid-phase hold-off until the block has drained
        if (p == 1 && !drained && items_sent >= goal - 150) begin
          wait_for_results();
          drained = 1'b1;
        end
      end
      free_run = 1'b0;
    end
    wait_for_results();
  endtask

  // Receiver stall drawn per result transaction
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    hand_result_t want;
    hand_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      sink_hold <= free_run ? 0 : $urandom_range(0, 3);
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ERR_SHOWN)
          $display("[%0t] result with nothing expected: %h", $realtime, out_tdata);
      end else begin
        want = due_results.pop_front();
        if (got.hour_pulses !== want.hour_pulses ||
            got.minute_pulses !== want.minute_pulses ||
            got.started !== want.started || got.busy !== want.busy ||
            got.refused !== want.refused || got.hour !== want.hour ||
            got.minute !== want.minute || got.second !== want.second) begin
          mismatches++;
          if (mismatches <= ERR_SHOWN)
            $display({"[%0t] mismatch exp hp=%0d mp=%0d st=%0b bsy=%0b ref=%0b %0d:%0d:%0d",
                      " got hp=%0d mp=%0d st=%0b bsy=%0b ref=%0b %0d:%0d:%0d"},
                     $realtime, want.hour_pulses, want.minute_pulses, want.started,
                     want.busy, want.refused, want.hour, want.minute, want.second,
                     got.hour_pulses, got.minute_pulses, got.started, got.busy,
                     got.refused, got.hour, got.minute, got.second);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("pulse_clock_hand_driver_unit test failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = pchd_pkg::ACT_TICK;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_mark_extremes();
    test_random_traffic();

    repeat (5) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results over %0d home mark writes",
             items_sent, results_seen, mark_writes);
    $display("Homing starts %0d, refused sets %0d, tick carries %0d, mismatches %0d",
             homing_count, refused_count, carry_count, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("pulse_clock_hand_driver_unit test passed");
    end else begin
      $display("pulse_clock_hand_driver_unit test failed");
    end
    $finish;
  end

endmodule

// File: pulse_clock_hand_driver_unit.f
rtl/core/pchd_pkg.sv
rtl/core/pchd_timekeeper.sv
rtl/core/pchd_homing.sv
rtl/core/pulse_clock_hand_driver_unit.sv
tb/pulse_clock_hand_driver_unit_tb.sv
